FILE: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define CHK_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication that must hold on the next clock edge.
`define CHK_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/dfs_pkg.sv
// Types, constants and helpers for the dielectric Fresnel sampler.
package dfs_pkg;

  localparam int DIR_FRAC_BITS = 14;
  localparam int Q30_SH        = 30 - DIR_FRAC_BITS;
  localparam int DIR_ONE       = 1 << DIR_FRAC_BITS;
  localparam int DIR_HI        = (DIR_ONE < 32767) ? DIR_ONE : 32767;
  localparam int DIR_LO        = -((DIR_ONE < 32768) ? DIR_ONE : 32768);

  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
  localparam logic [13:0] ETA_UNITY = 14'd4096;
  localparam logic [15:0] PROB_ONE  = 16'h8000;

  localparam int SQRT_STAGES = 31;
  localparam int DIV_STAGES  = 31;

  typedef enum logic [2:0] {
    REG_ETA, REG_INV_ETA, REG_REFL_R, REG_REFL_G,
    REG_REFL_B, REG_TRANS_R, REG_TRANS_G, REG_TRANS_B
  } reg_idx_t;

  typedef struct packed {
    logic [13:0] eta;
    logic [13:0] inv_eta;
    logic [15:0] refl_r;
    logic [15:0] refl_g;
    logic [15:0] refl_b;
    logic [15:0] trans_r;
    logic [15:0] trans_g;
    logic [15:0] trans_b;
  } cfg_t;

  // Per-item data that rides along the pipeline.
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] u;
    logic        pos;
    logic        unity;
    logic        tir;
    logic [30:0] ci;
    logic [30:0] ct;
  } side_t;

  // One lane of the restoring divider.
  typedef struct packed {
    logic [33:0] den;
    logic [34:0] rem;
    logic [30:0] quo;
    logic        dz;
  } div_lane_t;

  // Saturate a direction component to +-1 within the 16 bit range.
  function automatic logic [15:0] dir_sat(input int v);
    logic [15:0] r;
    if (v > DIR_HI) r = 16'(DIR_HI);
    else if (v < DIR_LO) r = 16'(DIR_LO);
    else r = 16'(v);
    return r;
  endfunction

endpackage

FILE: design/dfs_front.sv
// Front stages: cosine clamp, squares and the transmitted sine term.
module dfs_front import dfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [15:0] in_x,
  input  logic [15:0] in_y,
  input  logic [15:0] in_z,
  input  logic [15:0] in_u,
  input  cfg_t        cfg,
  output logic        out_valid,
  output side_t       out_side,
  output logic [61:0] out_rad
);

  logic        v1, v2, v3;
  side_t       side1, side2, side3;
  logic [13:0] s1;
  logic [61:0] cc2;
  logic [27:0] ss2;
  logic [58:0] prod3;

  int          zs, zc, zabs;
  side_t       side1_next;
  logic [30:0] sin2;
  logic [34:0] t4;
  logic        tir4;
  logic [30:0] rad4;
  side_t       side4;

  // Clamp the cosine and pick the sine scale.
  always_comb begin
    zs   = int'($signed(in_z));
    zc   = (zs > DIR_ONE) ? DIR_ONE : ((zs < -DIR_ONE) ? -DIR_ONE : zs);
    zabs = (zc < 0) ? -zc : zc;
    side1_next       = '0;
    side1_next.x     = in_x;
    side1_next.y     = in_y;
    side1_next.u     = in_u;
    side1_next.pos   = (zc > 0);
    side1_next.unity = (cfg.eta == ETA_UNITY);
    side1_next.ci    = 31'(zabs << Q30_SH);
  end

  always_comb begin
    sin2 = Q30_ONE - 31'(cc2 >> 30);
    t4   = 35'(prod3 >> 24);
    tir4 = (t4 >= {4'b0, Q30_ONE});
    rad4 = tir4 ? 31'd0 : (Q30_ONE - t4[30:0]);
    side4     = side3;
    side4.tir = tir4;
  end

  // Advance valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= side1_next;
      s1    <= side1_next.pos ? cfg.inv_eta : cfg.eta;
      side2 <= side1;
      cc2   <= 62'(side1.ci) * 62'(side1.ci);
      ss2   <= 28'(s1) * 28'(s1);
      side3 <= side2;
      prod3 <= 59'(sin2) * 59'(ss2);
      out_side <= side4;
      out_rad  <= {1'b0, rad4, 30'd0};
    end
  end

endmodule

FILE: design/dfs_sqrt.sv
// Pipelined digit-by-digit square root, one root bit per stage.
module dfs_sqrt import dfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  side_t       in_side,
  input  logic [61:0] in_rad,
  output logic        out_valid,
  output side_t       out_side
);

  logic        v_a    [0:SQRT_STAGES];
  side_t       side_a [0:SQRT_STAGES];
  logic [34:0] rem_a  [0:SQRT_STAGES];
  logic [30:0] q_a    [0:SQRT_STAGES];
  logic [61:0] n_a    [0:SQRT_STAGES];

  assign v_a[0]    = in_valid;
  assign side_a[0] = in_side;
  assign rem_a[0]  = '0;
  assign q_a[0]    = '0;
  assign n_a[0]    = in_rad;

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    logic [34:0] sh, trial;
    logic        ge;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
      sh    = {rem_a[j][32:0], n_a[j][61:60]};
      trial = {2'b00, q_a[j], 2'b01};
      ge    = (sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_a[j+1] <= 1'b0;
      end else if (en) begin
        v_a[j+1] <= v_a[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_a[j+1] <= side_a[j];
        rem_a[j+1]  <= ge ? (sh - trial) : sh;
        q_a[j+1]    <= {q_a[j][29:0], ge};
        n_a[j+1]    <= {n_a[j][59:0], 2'b00};
      end
    end
  end

  always_comb begin
    out_valid   = v_a[SQRT_STAGES];
    out_side    = side_a[SQRT_STAGES];
    out_side.ct = q_a[SQRT_STAGES];
  end

endmodule

FILE: design/dfs_ratio.sv
// Fresnel ratios: scaled cosines, two pipelined dividers and the average of the squares.
module dfs_ratio import dfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  side_t       in_side,
  input  cfg_t        cfg,
  output logic        out_valid,
  output side_t       out_side,
  output logic [15:0] out_f15
);

  // Scaled cosine stage.
  logic        v0;
  side_t       side0;
  logic [32:0] ect0, eci0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side0 <= in_side;
      ect0  <= 33'((45'(cfg.eta) * 45'(in_side.ct)) >> 12);
      eci0  <= 33'((45'(cfg.eta) * 45'(in_side.ci)) >> 12);
    end
  end

  // Divider lanes: lane 0 is (ci, e*ct), lane 1 is (e*ci, ct).
  logic      v_a    [1:DIV_STAGES];
  side_t     side_a [1:DIV_STAGES];
  div_lane_t lane_a [1:DIV_STAGES][0:1];

  logic [32:0] opa [0:1];
  logic [32:0] opb [0:1];

  assign opa[0] = {2'b00, side0.ci};
  assign opb[0] = ect0;
  assign opa[1] = eci0;
  assign opb[1] = {2'b00, side0.ct};

  always_ff @(posedge clk) begin
    if (rst) v_a[1] <= 1'b0;
    else if (en) v_a[1] <= v0;
  end

  always_ff @(posedge clk) begin
    if (en) side_a[1] <= side0;
  end

  for (genvar l = 0; l < 2; l++) begin : g_init
    logic [33:0] den, num;
    logic        ge;

    // Form sum and difference and decide the top quotient bit.
    always_comb begin
      den = 34'(opa[l]) + 34'(opb[l]);
      num = (opa[l] > opb[l]) ? 34'(opa[l] - opb[l]) : 34'(opb[l] - opa[l]);
      ge  = (num >= den);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lane_a[1][l].den <= den;
        lane_a[1][l].rem <= {1'b0, ge ? (num - den) : num};
        lane_a[1][l].quo <= {30'd0, ge};
        lane_a[1][l].dz  <= (den == 34'd0);
      end
    end
  end

  for (genvar j = 1; j < DIV_STAGES; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) v_a[j+1] <= 1'b0;
      else if (en) v_a[j+1] <= v_a[j];
    end

    always_ff @(posedge clk) begin
      if (en) side_a[j+1] <= side_a[j];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [34:0] sh, dd;
      logic        ge;

      // Shift the partial remainder and subtract where it fits.
      always_comb begin
        sh = {lane_a[j][l].rem[33:0], 1'b0};
        dd = {1'b0, lane_a[j][l].den};
        ge = (sh >= dd);
      end

      always_ff @(posedge clk) begin
        if (en) begin
          lane_a[j+1][l].den <= lane_a[j][l].den;
          lane_a[j+1][l].rem <= ge ? (sh - dd) : sh;
          lane_a[j+1][l].quo <= {lane_a[j][l].quo[29:0], ge};
          lane_a[j+1][l].dz  <= lane_a[j][l].dz;
        end
      end
    end
  end

  // Square each ratio.
  logic        vq;
  side_t       sideq;
  logic [61:0] sq   [0:1];
  logic        dzq  [0:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vq        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vq        <= v_a[DIV_STAGES];
      out_valid <= vq;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en) begin
        sq[l]  <= 62'(lane_a[DIV_STAGES][l].quo) * 62'(lane_a[DIV_STAGES][l].quo);
        dzq[l] <= lane_a[DIV_STAGES][l].dz;
      end
    end
  end

  // Average the two terms and apply the index-one and total reflection cases.
  logic [30:0] rsq [0:1];
  logic [31:0] fsum;
  logic [15:0] f15;

  always_comb begin
    rsq[0] = dzq[0] ? Q30_ONE : 31'(sq[0] >> 30);
    rsq[1] = dzq[1] ? Q30_ONE : 31'(sq[1] >> 30);
    fsum   = (32'(rsq[0]) + 32'(rsq[1])) >> 1;
    if (sideq.unity) f15 = 16'd0;
    else if (sideq.tir) f15 = PROB_ONE;
    else f15 = 16'(fsum >> 15);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sideq    <= side_a[DIV_STAGES];
      out_side <= sideq;
      out_f15  <= f15;
    end
  end

endmodule

FILE: design/dfs_back.sv
// Output stage: lobe choice, direction build, saturation and output register.
module dfs_back import dfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  side_t       in_side,
  input  logic [15:0] in_f15,
  input  cfg_t        cfg,
  output logic        out_valid,
  output logic [15:0] dir_x,
  output logic [15:0] dir_y,
  output logic [15:0] dir_z,
  output logic [15:0] prob,
  output logic        transmitted,
  output logic [15:0] weight_r,
  output logic [15:0] weight_g,
  output logic [15:0] weight_b
);

  logic [30:0] ctmag;
  logic        neg;
  logic [13:0] k;
  int          zm, oz, zc, xs, ys, ax, ay, nsx, nsy;
  logic [30:0] px, py;
  logic        refl;

  // Build both candidate directions and pick one.
  always_comb begin
    ctmag = in_side.unity ? in_side.ci : (in_side.tir ? 31'd0 : in_side.ct);
    neg   = in_side.pos && (ctmag != 31'd0);
    k     = neg ? cfg.inv_eta : cfg.eta;
    zm    = int'(ctmag >> Q30_SH);
    oz    = neg ? -zm : zm;
    zc    = in_side.pos ? int'(in_side.ci >> Q30_SH) : -int'(in_side.ci >> Q30_SH);
    xs    = int'($signed(in_side.x));
    ys    = int'($signed(in_side.y));
    ax    = (xs < 0) ? -xs : xs;
    ay    = (ys < 0) ? -ys : ys;
    px    = 31'(17'(ax)) * 31'(k);
    py    = 31'(17'(ay)) * 31'(k);
    nsx   = (xs < 0) ? int'(px >> 12) : -int'(px >> 12);
    nsy   = (ys < 0) ? int'(py >> 12) : -int'(py >> 12);
    refl  = (in_side.u <= in_f15);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (refl) begin
        dir_x       <= dir_sat(-xs);
        dir_y       <= dir_sat(-ys);
        dir_z       <= dir_sat(zc);
        prob        <= in_f15;
        transmitted <= 1'b0;
        weight_r    <= cfg.refl_r;
        weight_g    <= cfg.refl_g;
        weight_b    <= cfg.refl_b;
      end else begin
        dir_x       <= dir_sat(nsx);
        dir_y       <= dir_sat(nsy);
        dir_z       <= dir_sat(oz);
        prob        <= PROB_ONE - in_f15;
        transmitted <= 1'b1;
        weight_r    <= cfg.trans_r;
        weight_g    <= cfg.trans_g;
        weight_b    <= cfg.trans_b;
      end
    end
  end

endmodule

FILE: design/dielectric_fresnel_sampler_unit.sv
// Throughput: one beat per cycle while the output beat is not held;
// the 31-stage root and 31-stage dividers are fully pipelined.
// A stalled output beat freezes the whole pipeline in place; s_tready = !m_tvalid || m_tready.
// Reset (synchronous, rst high) clears all valid bits and loads register defaults:
// eta 1.5, inv_eta 1/1.5, reflectance 0.5 and transmittance 1.0 per channel.
`include "assert_macros.svh"
module dielectric_fresnel_sampler_unit import dfs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // in_dir_x[15:0], in_dir_y[31:16], in_dir_z[47:32], sample_u[63:48]
  input  logic [63:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_dir_x[15:0], out_dir_y[31:16], out_dir_z[47:32], prob[63:48],
  // weight_r[79:64], weight_g[95:80], weight_b[111:96]
  output logic [111:0] m_tdata,
  // transmitted[0]
  output logic [0:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  cfg_t  cfg;
  logic  en;
  logic  f_valid, s_valid, r_valid;
  side_t f_side, s_side, r_side;
  logic [61:0] f_rad;
  logic [15:0] r_f15;
  logic [15:0] o_x, o_y, o_z, o_prob, o_wr, o_wg, o_wb;
  logic        o_trans;

  // Advance everything unless the output beat is held.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.eta     <= 14'd6144;
      cfg.inv_eta <= 14'd2731;
      cfg.refl_r  <= 16'd16384;
      cfg.refl_g  <= 16'd16384;
      cfg.refl_b  <= 16'd16384;
      cfg.trans_r <= 16'd32768;
      cfg.trans_g <= 16'd32768;
      cfg.trans_b <= 16'd32768;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ETA:     cfg.eta     <= cfg_data[13:0];
        REG_INV_ETA: cfg.inv_eta <= cfg_data[13:0];
        REG_REFL_R:  cfg.refl_r  <= cfg_data;
        REG_REFL_G:  cfg.refl_g  <= cfg_data;
        REG_REFL_B:  cfg.refl_b  <= cfg_data;
        REG_TRANS_R: cfg.trans_r <= cfg_data;
        REG_TRANS_G: cfg.trans_g <= cfg_data;
        REG_TRANS_B: cfg.trans_b <= cfg_data;
        default: ;
      endcase
    end
  end

  dfs_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid && s_tready),
    .in_x(s_tdata[15:0]), .in_y(s_tdata[31:16]), .in_z(s_tdata[47:32]),
    .in_u(s_tdata[63:48]), .cfg(cfg),
    .out_valid(f_valid), .out_side(f_side), .out_rad(f_rad)
  );

  dfs_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid), .in_side(f_side),
    .in_rad(f_rad), .out_valid(s_valid), .out_side(s_side)
  );

  dfs_ratio u_ratio (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_valid), .in_side(s_side),
    .cfg(cfg), .out_valid(r_valid), .out_side(r_side), .out_f15(r_f15)
  );

  dfs_back u_back (
    .clk(clk), .rst(rst), .en(en), .in_valid(r_valid), .in_side(r_side),
    .in_f15(r_f15), .cfg(cfg), .out_valid(m_tvalid),
    .dir_x(o_x), .dir_y(o_y), .dir_z(o_z), .prob(o_prob),
    .transmitted(o_trans), .weight_r(o_wr), .weight_g(o_wg), .weight_b(o_wb)
  );

  assign m_tdata = {o_wb, o_wg, o_wr, o_prob, o_z, o_y, o_x};
  assign m_tuser = o_trans;

  `CHK_NOW(a_ready_flow, clk, rst, 1'b1, s_tready == (!m_tvalid || m_tready), "ready mismatch")
  `CHK_NOW(a_prob_range, clk, rst, m_tvalid, o_prob <= PROB_ONE, "prob above one")
  `CHK_NOW(a_refl_z, clk, rst, m_tvalid && !o_trans, o_z != 16'h7fff, "reflect z out of range")
  `CHK_NEXT(a_reset_empty, clk, rst, !m_tvalid, "output valid after reset")

endmodule
